/* hw/rtl/mec_pkg.sv */
// ----------------------------------------------------------------------------
// mec_pkg
// shared constants for the mandelbrot escape counter
// ----------------------------------------------------------------------------
package mec_pkg;

    localparam int C_W         = 32;   // width of c_re / c_im
    localparam int CFG_W       = 16;   // width of max_count
    localparam int RES_W       = 16;   // width of escape_count
    localparam int QUEUE_DEPTH = 2;    // depth of the request and result queues

    localparam logic [CFG_W-1:0] MAX_COUNT_RST = 16'd255;

endpackage

/* hw/rtl/mec_queue.sv */
// ----------------------------------------------------------------------------
// mec_queue
// small first-in first-out queue used between the stages of the block
// ----------------------------------------------------------------------------
module mec_queue #(
    parameter int WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = $clog2(mec_pkg::QUEUE_DEPTH);

    logic [WIDTH-1:0] r_mem [mec_pkg::QUEUE_DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [AW:0]      r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == (AW+1)'(mec_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

/* hw/rtl/mec_front.sv */
// ----------------------------------------------------------------------------
// mec_front
// request front end: clamps the start point into z range and the limit
// ----------------------------------------------------------------------------
module mec_front #(
    parameter int FRAC_BITS  = 28,
    parameter int COUNT_BITS = 16
) (
    input  logic signed [mec_pkg::C_W-1:0]   i_c_re,
    input  logic signed [mec_pkg::C_W-1:0]   i_c_im,
    input  logic        [mec_pkg::CFG_W-1:0] i_max_count,
    output logic signed [FRAC_BITS+7:0]      o_zr0,
    output logic signed [FRAC_BITS+7:0]      o_zi0,
    output logic        [COUNT_BITS-1:0]     o_limit
);

    localparam int ZW = FRAC_BITS + 8;
    localparam int FW = (ZW + 1 > mec_pkg::C_W + 1) ? ZW + 1 : mec_pkg::C_W + 1;
    localparam logic [FW-1:0] ZMAX_U = (FW'(1) << (ZW - 1)) - FW'(1);
    localparam logic [31:0]   CAP    = 32'((64'(1) << COUNT_BITS) - 64'(1));

    logic signed [FW-1:0] ext_re;
    logic signed [FW-1:0] ext_im;
    logic [31:0]          max32;

    function automatic logic [ZW-1:0] sat_z(input logic signed [FW-1:0] v);
        if (v > $signed(ZMAX_U)) begin
            return ZW'(ZMAX_U);
        end else if (v < $signed(~ZMAX_U)) begin
            return ZW'(~ZMAX_U);
        end else begin
            return ZW'(v);
        end
    endfunction

    always_comb begin
        ext_re  = FW'(i_c_re);
        ext_im  = FW'(i_c_im);
        o_zr0   = sat_z(ext_re);
        o_zi0   = sat_z(ext_im);
        max32   = 32'(i_max_count);
        o_limit = (max32 > CAP) ? CAP[COUNT_BITS-1:0] : max32[COUNT_BITS-1:0];
    end

endmodule

/* hw/rtl/mec_core.sv */
// ----------------------------------------------------------------------------
// mec_core
// iteration engine: z = z^2 + c with escape test, a multiply state then an update state per iteration
// ----------------------------------------------------------------------------
module mec_core #(
    parameter int FRAC_BITS  = 28,
    parameter int COUNT_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_empty,
    input  logic signed [mec_pkg::C_W-1:0]   i_c_re,
    input  logic signed [mec_pkg::C_W-1:0]   i_c_im,
    input  logic signed [FRAC_BITS+7:0]      i_zr0,
    input  logic signed [FRAC_BITS+7:0]      i_zi0,
    input  logic        [COUNT_BITS-1:0]     i_limit,
    output logic                             o_pop,
    input  logic                             i_full,
    output logic                             o_push,
    output logic        [mec_pkg::RES_W-1:0] o_result
);

    localparam int ZW = FRAC_BITS + 8;
    localparam int MW = FRAC_BITS + 2;
    localparam int PW = 2 * MW;
    localparam int SW = (PW + 3 > mec_pkg::C_W + 2) ? PW + 3 : mec_pkg::C_W + 2;
    localparam logic [ZW-1:0] TWO    = ZW'(1) << (FRAC_BITS + 1);
    localparam logic [PW:0]   FOUR   = (PW+1)'(1) << (2 * FRAC_BITS + 2);
    localparam logic [SW-1:0] ZMAX_U = (SW'(1) << (ZW - 1)) - SW'(1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_UPD,
        S_DONE
    } t_state;

    t_state                         r_state;
    logic signed [ZW-1:0]           r_zr;
    logic signed [ZW-1:0]           r_zi;
    logic signed [mec_pkg::C_W-1:0] r_cr;
    logic signed [mec_pkg::C_W-1:0] r_ci;
    logic [COUNT_BITS-1:0]          r_cnt;
    logic [COUNT_BITS-1:0]          r_limit;
    logic [PW-1:0]                  r_aa;
    logic [PW-1:0]                  r_bb;
    logic [PW-1:0]                  r_ab;
    logic                           r_big;
    logic                           r_neg;
    logic [mec_pkg::RES_W-1:0]      r_res;

    logic [ZW-1:0]         abs_r;
    logic [ZW-1:0]         abs_i;
    logic [MW-1:0]         op_r;
    logic [MW-1:0]         op_i;
    logic [PW-1:0]         m_aa;
    logic [PW-1:0]         m_bb;
    logic [PW-1:0]         m_ab;
    logic                  big;
    logic [PW:0]           mag2;
    logic                  esc;
    logic signed [PW:0]    diff;
    logic signed [PW:0]    re_sh;
    logic signed [PW+1:0]  ab2;
    logic signed [PW+1:0]  im_v;
    logic signed [PW+1:0]  im_sh;
    logic signed [SW-1:0]  re_sum;
    logic signed [SW-1:0]  im_sum;
    logic [ZW-1:0]         zr_next;
    logic [ZW-1:0]         zi_next;
    logic [COUNT_BITS-1:0] cnt_inc;

    function automatic logic [ZW-1:0] sat_z(input logic signed [SW-1:0] v);
        if (v > $signed(ZMAX_U)) begin
            return ZW'(ZMAX_U);
        end else if (v < $signed(~ZMAX_U)) begin
            return ZW'(~ZMAX_U);
        end else begin
            return ZW'(v);
        end
    endfunction

    // multiply phase
    always_comb begin
        abs_r = r_zr[ZW-1] ? ZW'(~r_zr + 1'b1) : ZW'(r_zr);
        abs_i = r_zi[ZW-1] ? ZW'(~r_zi + 1'b1) : ZW'(r_zi);
        big   = (abs_r > TWO) || (abs_i > TWO);
        op_r  = abs_r[MW-1:0];
        op_i  = abs_i[MW-1:0];
        m_aa  = PW'(op_r) * PW'(op_r);
        m_bb  = PW'(op_i) * PW'(op_i);
        m_ab  = PW'(op_r) * PW'(op_i);
    end

    // update phase
    always_comb begin
        mag2    = {1'b0, r_aa} + {1'b0, r_bb};
        esc     = r_big || (mag2 > FOUR);
        diff    = $signed({1'b0, r_aa}) - $signed({1'b0, r_bb});
        re_sh   = diff >>> FRAC_BITS;
        ab2     = $signed({1'b0, r_ab, 1'b0});
        im_v    = r_neg ? -ab2 : ab2;
        im_sh   = im_v >>> FRAC_BITS;
        re_sum  = SW'(re_sh) + SW'(r_cr);
        im_sum  = SW'(im_sh) + SW'(r_ci);
        zr_next = sat_z(re_sum);
        zi_next = sat_z(im_sum);
        cnt_inc = r_cnt + 1'b1;
    end

    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign o_push   = (r_state == S_DONE) && !i_full;
    assign o_result = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_cr    <= i_c_re;
                        r_ci    <= i_c_im;
                        r_zr    <= i_zr0;
                        r_zi    <= i_zi0;
                        r_limit <= i_limit;
                        r_cnt   <= '0;
                        r_res   <= '0;
                        r_state <= (i_limit == '0) ? S_DONE : S_MUL;
                    end
                end
                S_MUL: begin
                    r_aa    <= m_aa;
                    r_bb    <= m_bb;
                    r_ab    <= m_ab;
                    r_big   <= big;
                    r_neg   <= r_zr[ZW-1] ^ r_zi[ZW-1];
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (esc) begin
                        r_res   <= mec_pkg::RES_W'(r_cnt);
                        r_state <= S_DONE;
                    end else begin
                        r_zr  <= zr_next;
                        r_zi  <= zi_next;
                        r_cnt <= cnt_inc;
                        if (cnt_inc == r_limit) begin
                            r_res   <= mec_pkg::RES_W'(r_limit);
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_DONE: begin
                    if (!i_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* hw/rtl/mandelbrot_escape_count.sv */
// the engine makes t magnitude tests per point, one per iteration: iterations + 1
// when the point escapes, max_count when it does not, 0 for max_count = 0
// the engine holds one point at a time and takes no new request until its result is pushed;
// the square/cross multipliers are reused: each iteration runs multiply, then update and escape test
// a two-entry request queue and a two-entry result queue decouple both sides
// synchronous active-low reset empties the queues, idles the engine, max_count = 255
// ----------------------------------------------------------------------------
// mandelbrot_escape_count
// escape-time counter for one complex point per request
// ----------------------------------------------------------------------------
module mandelbrot_escape_count #(
    parameter int FRAC_BITS  = 28,
    parameter int COUNT_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    output logic                             o_full,
    input  logic signed [mec_pkg::C_W-1:0]   i_c_re,
    input  logic signed [mec_pkg::C_W-1:0]   i_c_im,
    output logic                             o_empty,
    input  logic                             i_pop,
    output logic        [mec_pkg::RES_W-1:0] o_escape_count,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic        [mec_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int ZW = FRAC_BITS + 8;
    localparam int QW = 2 * mec_pkg::C_W + 2 * ZW + COUNT_BITS;

    logic [mec_pkg::CFG_W-1:0] r_max_count;

    logic signed [ZW-1:0]           f_zr0;
    logic signed [ZW-1:0]           f_zi0;
    logic [COUNT_BITS-1:0]          f_limit;
    logic [QW-1:0]                  q_wdata;
    logic [QW-1:0]                  q_rdata;
    logic                           q_empty;
    logic                           q_pop;
    logic signed [mec_pkg::C_W-1:0] b_cr;
    logic signed [mec_pkg::C_W-1:0] b_ci;
    logic signed [ZW-1:0]           b_zr0;
    logic signed [ZW-1:0]           b_zi0;
    logic [COUNT_BITS-1:0]          b_limit;
    logic                           res_push;
    logic                           res_full;
    logic [mec_pkg::RES_W-1:0]      res_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_count <= mec_pkg::MAX_COUNT_RST;
        end else if (i_cfg_valid) begin
            r_max_count <= i_cfg_data;
        end
    end

    mec_front #(
        .FRAC_BITS  (FRAC_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_c_re      (i_c_re),
        .i_c_im      (i_c_im),
        .i_max_count (r_max_count),
        .o_zr0       (f_zr0),
        .o_zi0       (f_zi0),
        .o_limit     (f_limit)
    );

    assign q_wdata = {i_c_re, i_c_im, f_zr0, f_zi0, f_limit};

    mec_queue #(
        .WIDTH (QW)
    ) u_req_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (q_wdata),
        .o_full  (o_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    assign {b_cr, b_ci, b_zr0, b_zi0, b_limit} = q_rdata;

    mec_core #(
        .FRAC_BITS  (FRAC_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (q_empty),
        .i_c_re   (b_cr),
        .i_c_im   (b_ci),
        .i_zr0    (b_zr0),
        .i_zi0    (b_zi0),
        .i_limit  (b_limit),
        .o_pop    (q_pop),
        .i_full   (res_full),
        .o_push   (res_push),
        .o_result (res_data)
    );

    mec_queue #(
        .WIDTH (mec_pkg::RES_W)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_data),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_data  (o_escape_count),
        .o_empty (o_empty)
    );

endmodule
